FILE: hdl/plane_box_edge_intercepts_core_assert.svh
// Assertion macros used by the checker file.
`ifndef PLANE_BOX_EDGE_INTERCEPTS_CORE_ASSERT_SVH
`define PLANE_BOX_EDGE_INTERCEPTS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PBEI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PBEI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pbei_pkg.sv
`default_nettype none
package pbei_pkg;

    localparam int CW         = 32;           // coordinate width, Q16.16
    localparam int NW         = 16;           // normal width, Q2.14
    localparam int PW         = CW + NW;      // one product
    localparam int DW         = PW + 2;       // sum of three products
    localparam int NUMW       = PW + 3;       // numerator
    localparam int REMW       = NW + 1;       // divider partial remainder
    localparam int DIV_STEP   = 4;            // quotient bits per divider stage
    localparam int DIV_STAGES = CW / DIV_STEP;

    localparam logic [3:0] LAST_EDGE = 4'd11;

    // register indexes
    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_NRM_X = 3'd3;
    localparam logic [2:0] REG_NRM_Y = 3'd4;
    localparam logic [2:0] REG_NRM_Z = 3'd5;

    localparam logic signed [NW-1:0] NRM_Z_RESET = 16'sd16384;

    typedef struct packed {
        logic signed [CW-1:0] box_min_x;
        logic signed [CW-1:0] box_min_y;
        logic signed [CW-1:0] box_min_z;
        logic signed [CW-1:0] box_max_x;
        logic signed [CW-1:0] box_max_y;
        logic signed [CW-1:0] box_max_z;
    } t_box;

    typedef struct packed {
        logic signed [CW-1:0] vertex_x;
        logic signed [CW-1:0] vertex_y;
        logic signed [CW-1:0] vertex_z;
        logic [3:0]           edge_number;
        logic                 found;
        logic                 last_vertex;
    } t_res;

    // per-edge control and fixed coordinates riding down the pipe
    typedef struct packed {
        logic                  valid;
        logic [3:0]            edge_no;
        logic [1:0]            fk;
        logic                  hit;
        logic                  neg;
        logic [2:0][CW-1:0]    v;
    } t_edge_ctl;

endpackage
`default_nettype wire

FILE: hdl/plane_box_edge_intercepts_core.sv
// Plane / axis-aligned box edge intercepts.
// Input channel: one box per transfer (i_valid, o_stall, i_box). Output channel:
// one vertex result per transfer (o_valid, i_stall, o_res). A box yields one
// result for each box edge the plane crosses, in edge order, the final
// one flagged last_vertex; a box with no crossing yields a single result with
// found cleared. Plane origin and normal sit in six registers written through
// i_cfg_wr_en / i_cfg_index / i_cfg_wdata; write them only while the block is idle.
// Throughput: one edge per cycle while the pipe is not stalled, fed by the edge
// sequencer into a shared multiply / compare / divide pipe.
// Stages: operand select, four 32x16 products, numerator and range test, eight
// radix-16 divider stages, floor fix, result collector.
// The collector holds one hit back to learn whether it is the last; results
// land in a 4-entry output queue.
// Output stall: when the queue has fewer than two free slots the whole pipe and
// the sequencer freeze; nothing is lost or repeated. New boxes keep being
// taken while earlier edges are in flight.
// Reset (synchronous, active low): pipe and queue empty, origin 0, normal +z.
`default_nettype none
module plane_box_edge_intercepts_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire pbei_pkg::t_box i_box,
    output logic                o_valid,
    input  wire logic           i_stall,
    output pbei_pkg::t_res      o_res,
    input  wire logic           i_cfg_wr_en,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_wdata
);
    localparam int CW   = pbei_pkg::CW;
    localparam int NW   = pbei_pkg::NW;
    localparam int PW   = pbei_pkg::PW;
    localparam int DW   = pbei_pkg::DW;
    localparam int NUMW = pbei_pkg::NUMW;
    localparam int REMW = pbei_pkg::REMW;
    localparam int DS   = pbei_pkg::DIV_STAGES;
    localparam int STEP = pbei_pkg::DIV_STEP;

    // ---------------- configuration ----------------
    logic signed [CW-1:0] r_org [3];
    logic signed [NW-1:0] r_nrm [3];
    logic signed [PW-1:0] r_dot_p [3];
    logic signed [DW-1:0] r_dot0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_nrm[0] <= '0;
            r_nrm[1] <= '0;
            r_nrm[2] <= pbei_pkg::NRM_Z_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pbei_pkg::REG_ORG_X: r_org[0] <= i_cfg_wdata[CW-1:0];
                pbei_pkg::REG_ORG_Y: r_org[1] <= i_cfg_wdata[CW-1:0];
                pbei_pkg::REG_ORG_Z: r_org[2] <= i_cfg_wdata[CW-1:0];
                pbei_pkg::REG_NRM_X: r_nrm[0] <= i_cfg_wdata[NW-1:0];
                pbei_pkg::REG_NRM_Y: r_nrm[1] <= i_cfg_wdata[NW-1:0];
                pbei_pkg::REG_NRM_Z: r_nrm[2] <= i_cfg_wdata[NW-1:0];
                default: ;
            endcase
        end
    end

    // n.o, recomputed continuously through a product register and a sum register
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_dot_p[k] <= r_nrm[k] * r_org[k];
        end
        r_dot0 <= DW'(r_dot_p[0]) + DW'(r_dot_p[1]) + DW'(r_dot_p[2]);
    end

    // ---------------- flow control ----------------
    logic       adv;          // whole pipe moves
    logic [2:0] r_count;
    logic       r_busy;
    logic [3:0] r_edge;
    pbei_pkg::t_box r_box;
    logic       accept;

    assign adv     = (r_count <= 3'd2);
    assign o_stall = r_busy && !(adv && r_edge == pbei_pkg::LAST_EDGE);
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_edge <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_edge <= '0;
        end else if (r_busy && adv) begin
            if (r_edge == pbei_pkg::LAST_EDGE) begin
                r_busy <= 1'b0;
            end
            r_edge <= r_edge + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_box <= i_box;
        end
    end

    // ---------------- edge geometry ----------------
    logic signed [CW-1:0] bmin [3];
    logic signed [CW-1:0] bmax [3];
    logic [1:0] fk, ia, ib;
    logic       sa, sb;
    pbei_pkg::t_edge_ctl n_ctl1;
    logic signed [CW-1:0] n_ca, n_cb;

    always_comb begin
        bmin[0] = r_box.box_min_x;
        bmin[1] = r_box.box_min_y;
        bmin[2] = r_box.box_min_z;
        bmax[0] = r_box.box_max_x;
        bmax[1] = r_box.box_max_y;
        bmax[2] = r_box.box_max_z;
        sa = r_edge[0];
        sb = r_edge[0] ^ r_edge[1];
        unique case (r_edge[3:2])
            2'd0:    begin fk = 2'd2; ia = 2'd0; ib = 2'd1; end
            2'd1:    begin fk = 2'd1; ia = 2'd0; ib = 2'd2; end
            default: begin fk = 2'd0; ia = 2'd1; ib = 2'd2; end
        endcase
        n_ca = sa ? bmax[ia] : bmin[ia];
        n_cb = sb ? bmax[ib] : bmin[ib];
        n_ctl1         = '0;
        n_ctl1.valid   = r_busy;
        n_ctl1.edge_no = r_edge;
        n_ctl1.fk      = fk;
        n_ctl1.v[ia]   = n_ca;
        n_ctl1.v[ib]   = n_cb;
    end

    // ---------------- stage 1: operands ----------------
    pbei_pkg::t_edge_ctl  r_ctl1;
    logic signed [NW-1:0] r_na1, r_nb1, r_d1;
    logic signed [CW-1:0] r_ca1, r_cb1, r_lo1, r_hi1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
        end else if (adv) begin
            r_ctl1 <= n_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_na1 <= r_nrm[ia];
            r_nb1 <= r_nrm[ib];
            r_d1  <= r_nrm[fk];
            r_ca1 <= n_ca;
            r_cb1 <= n_cb;
            r_lo1 <= bmin[fk];
            r_hi1 <= bmax[fk];
        end
    end

    // ---------------- stage 2: products ----------------
    pbei_pkg::t_edge_ctl  r_ctl2;
    logic signed [PW-1:0] r_pa2, r_pb2, r_plo2, r_phi2;
    logic signed [NW-1:0] r_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2.valid <= 1'b0;
        end else if (adv) begin
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pa2  <= r_na1 * r_ca1;
            r_pb2  <= r_nb1 * r_cb1;
            r_plo2 <= r_lo1 * r_d1;
            r_phi2 <= r_hi1 * r_d1;
            r_d2   <= r_d1;
        end
    end

    // ---------------- stage 3: numerator, range test ----------------
    logic signed [NUMW-1:0] num, lo_e, hi_e;
    logic [NUMW-1:0]        mag;
    logic                   hit3;
    logic [NW-1:0]          md3;
    pbei_pkg::t_edge_ctl    n_ctl3;

    always_comb begin
        num  = NUMW'(r_dot0) - NUMW'(r_pa2) - NUMW'(r_pb2);
        lo_e = NUMW'(r_plo2);
        hi_e = NUMW'(r_phi2);
        mag  = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
        md3  = r_d2[NW-1] ? NW'(-r_d2) : NW'(r_d2);
        if (r_d2 == '0) begin
            hit3 = 1'b0;
        end else if (r_d2[NW-1]) begin
            hit3 = (hi_e <= num) && (num <= lo_e);
        end else begin
            hit3 = (lo_e <= num) && (num <= hi_e);
        end
        n_ctl3     = r_ctl2;
        n_ctl3.hit = hit3;
        n_ctl3.neg = num[NUMW-1] ^ r_d2[NW-1];
    end

    // ---------------- divider: |num| / |d|, STEP bits per stage ----------------
    pbei_pkg::t_edge_ctl r_dv_ctl [DS+1];
    logic [REMW-1:0]     r_dv_rem [DS+1];
    logic [CW-1:0]       r_dv_q   [DS+1];
    logic [NW-1:0]       r_dv_md  [DS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_ctl[0].valid <= 1'b0;
        end else if (adv) begin
            r_dv_ctl[0] <= n_ctl3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // high part is below |d| whenever the edge is a hit
            r_dv_rem[0] <= REMW'(mag[CW+NW-1:CW]);
            r_dv_q[0]   <= mag[CW-1:0];
            r_dv_md[0]  <= md3;
        end
    end

    for (genvar g = 0; g < DS; g++) begin : g_div
        logic [REMW-1:0] n_rem;
        logic [CW-1:0]   n_q;

        always_comb begin
            n_rem = r_dv_rem[g];
            n_q   = r_dv_q[g];
            for (int b = 0; b < STEP; b++) begin
                n_rem = {n_rem[REMW-2:0], n_q[CW-1]};
                n_q   = {n_q[CW-2:0], 1'b0};
                if (n_rem >= REMW'(r_dv_md[g])) begin
                    n_rem = n_rem - REMW'(r_dv_md[g]);
                    n_q[0] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_ctl[g+1].valid <= 1'b0;
            end else if (adv) begin
                r_dv_ctl[g+1] <= r_dv_ctl[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_rem[g+1] <= n_rem;
                r_dv_q[g+1]   <= n_q;
                r_dv_md[g+1]  <= r_dv_md[g];
            end
        end
    end

    // ---------------- floor fix, vertex assembly ----------------
    pbei_pkg::t_edge_ctl r_fin;
    pbei_pkg::t_edge_ctl n_fin;
    logic [CW-1:0]       qf;

    always_comb begin
        n_fin = r_dv_ctl[DS];
        if (n_fin.neg) begin
            qf = -r_dv_q[DS] - CW'(r_dv_rem[DS] != '0);
        end else begin
            qf = r_dv_q[DS];
        end
        n_fin.v[n_fin.fk] = qf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin.valid <= 1'b0;
        end else if (adv) begin
            r_fin <= n_fin;
        end
    end

    // ---------------- collector and output queue ----------------
    logic          r_have;
    pbei_pkg::t_res r_pend;
    pbei_pkg::t_res r_q [4];
    logic [1:0]    r_wr, r_rd;
    pbei_pkg::t_res new_res, empty_res, push0, push1;
    logic          do0, do1, pop, n_have;
    logic          in_v, at_end;

    always_comb begin
        in_v   = adv && r_fin.valid;
        at_end = r_fin.edge_no == pbei_pkg::LAST_EDGE;
        new_res.vertex_x    = r_fin.v[0];
        new_res.vertex_y    = r_fin.v[1];
        new_res.vertex_z    = r_fin.v[2];
        new_res.edge_number = r_fin.edge_no;
        new_res.found       = 1'b1;
        new_res.last_vertex = 1'b0;
        empty_res             = '0;
        empty_res.last_vertex = 1'b1;
        do0    = 1'b0;
        do1    = 1'b0;
        push0  = r_pend;
        push1  = new_res;
        n_have = r_have;
        if (in_v) begin
            if (at_end) begin
                n_have = 1'b0;
                if (r_fin.hit) begin
                    push1.last_vertex = 1'b1;
                    if (r_have) begin
                        do0 = 1'b1;
                        do1 = 1'b1;
                    end else begin
                        push0 = push1;
                        do0   = 1'b1;
                    end
                end else begin
                    do0 = 1'b1;
                    if (r_have) begin
                        push0.last_vertex = 1'b1;
                    end else begin
                        push0 = empty_res;
                    end
                end
            end else if (r_fin.hit) begin
                do0    = r_have;
                n_have = 1'b1;
            end
        end
        pop = o_valid && !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have  <= 1'b0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_have  <= n_have;
            r_wr    <= r_wr + 2'(do0) + 2'(do1);
            r_rd    <= r_rd + 2'(pop);
            r_count <= r_count + 3'(do0) + 3'(do1) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_v && r_fin.hit && !at_end) begin
            r_pend <= new_res;
        end
        if (do0) begin
            r_q[r_wr] <= push0;
        end
        if (do1) begin
            r_q[r_wr + 2'd1] <= push1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_res   = r_q[r_rd];

endmodule
`default_nettype wire

FILE: hdl/pbei_checker.sv
`default_nettype none
`include "plane_box_edge_intercepts_core_assert.svh"
module pbei_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_valid,
    input wire logic           i_stall,
    input wire pbei_pkg::t_res o_res
);
    `PBEI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_res), "stalled result changed")
    `PBEI_ASSERT_IMPLY(a_empty_last, i_clk, i_rst_n, o_valid && !o_res.found, o_res.last_vertex && o_res.edge_number == 4'd0, "empty result malformed")
    `PBEI_ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, o_valid && !o_res.found, o_res.vertex_x == '0 && o_res.vertex_y == '0 && o_res.vertex_z == '0, "empty result carries a vertex")
    `PBEI_ASSERT_IMPLY(a_edge_range, i_clk, i_rst_n, o_valid, o_res.edge_number <= 4'd11, "edge number out of range")
endmodule

bind plane_box_edge_intercepts_core pbei_checker u_pbei_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_res   (o_res)
);
`default_nettype wire
